### hw/rtl/fnvh_pkg.sv
// ----------------------------------------------------------------------------
// fnvh_pkg
// Shared constants, types and helper functions for the FNV-1 64-bit
// case-folded hex hasher.
// ----------------------------------------------------------------------------
package fnvh_pkg;

   localparam int HASH_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int NIB_W      = 4;
   localparam int CHAR_W     = 7;
   localparam int HEX_DIGITS = HASH_W / NIB_W;
   localparam int CNT_W      = $clog2(HEX_DIGITS);

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
   localparam logic [HASH_W-1:0] TOP_BIT   = 64'h8000_0000_0000_0000;

   localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
   localparam logic [NIB_W-1:0]  NIB_TEN    = 4'd10;
   localparam logic [CNT_W-1:0]  LAST_DIGIT = CNT_W'(HEX_DIGITS - 1);

   // Finished hash handed from the hash core to the serializer
   typedef struct packed {
      logic              load;
      logic [HASH_W-1:0] hash;
   } fnvh_load_type;

   // Fold ASCII upper case to lower case, other bytes unchanged
   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= UPPER_A && b <= UPPER_Z)
         r = b + CASE_DELTA;
      return r;
   endfunction

   // Multiply by the FNV prime 2^40 + 2^8 + 0xB3, modulo 2^64, as shifted adds
   function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] r;
      r = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
      return r;
   endfunction

   // One hash nibble to its upper-case ASCII hex digit
   function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [NIB_W-1:0] n);
      logic [CHAR_W-1:0] r;
      if (n < NIB_TEN)
         r = ASCII_ZERO + CHAR_W'(n);
      else
         r = ASCII_A + CHAR_W'(n - NIB_TEN);
      return r;
   endfunction

endpackage

### hw/rtl/fnvh_if.sv
// ----------------------------------------------------------------------------
// fnvh channel interfaces
// Valid/ready channels for message bytes, hex characters and the control
// register write port.
// ----------------------------------------------------------------------------
interface fnvh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       message_end;

   modport source (output valid, data_byte, byte_present, message_end, input ready);
   modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface fnvh_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] hex_char;
   logic       final_char;

   modport source (output valid, hex_char, final_char, input ready);
   modport sink   (input valid, hex_char, final_char, output ready);
endinterface

interface fnvh_csr_if;
   logic valid;
   logic ready;
   logic write_data;

   modport source (output valid, write_data, input ready);
   modport sink   (input valid, write_data, output ready);
endinterface

### hw/rtl/fnvh_hash_core.sv
// ----------------------------------------------------------------------------
// fnvh_hash_core
// Running FNV-1 64-bit hash: case fold, multiply by the prime, XOR the byte.
// Hands the finished hash to the serializer on a closing transfer.
// ----------------------------------------------------------------------------
module fnvh_hash_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_xfer,
   input  logic [fnvh_pkg::BYTE_W-1:0]  data_byte,
   input  logic                         byte_present,
   input  logic                         message_end,
   input  logic                         csr_xfer,
   input  logic                         csr_data,
   output fnvh_pkg::fnvh_load_type      load_out
);
   import fnvh_pkg::*;

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              force_top_ff, force_top_in;
   logic [HASH_W-1:0] stepped;

   // One FNV-1 step on the incoming byte
   always_comb begin
      stepped = hash_ff;
      if (byte_present)
         stepped = mul_prime(hash_ff) ^ HASH_W'(fold_case(data_byte));
   end

   // Next hash: advance, or restart after a closing transfer
   always_comb begin
      hash_in = hash_ff;
      if (req_xfer)
         hash_in = message_end ? FNV_BASIS : stepped;
   end

   // Control register
   always_comb begin
      force_top_in = csr_xfer ? csr_data : force_top_ff;
   end

   // Finished hash toward the serializer
   always_comb begin
      load_out.load = req_xfer && message_end;
      load_out.hash = force_top_ff ? (stepped | TOP_BIT) : stepped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= FNV_BASIS;
         force_top_ff <= 1'b1;
      end else begin
         hash_ff      <= hash_in;
         force_top_ff <= force_top_in;
      end
   end

   // A closing transfer leaves the basis behind
   a_restart: assert property (@(posedge clock) disable iff (reset)
      load_out.load |=> hash_ff == FNV_BASIS)
      else $error("hash not restarted after message end");

   // No transfer, no change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(hash_ff))
      else $error("hash changed without a transfer");

   // Forced top bit shows in the handed-off hash
   a_force: assert property (@(posedge clock) disable iff (reset)
      load_out.load && force_top_ff |-> load_out.hash[HASH_W-1])
      else $error("top bit not forced");

endmodule

### hw/rtl/fnvh_hex_serializer.sv
// ----------------------------------------------------------------------------
// fnvh_hex_serializer
// Sends finished hashes as upper-case hex characters, most significant
// nibble first, marking the last. One more hash waits while one goes out.
// ----------------------------------------------------------------------------
module fnvh_hex_serializer (
   input  logic                         clock,
   input  logic                         reset,
   input  fnvh_pkg::fnvh_load_type      load_in,
   output logic                         free,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fnvh_pkg::CHAR_W-1:0]  hex_char,
   output logic                         final_char
);
   import fnvh_pkg::*;

   logic [HASH_W-1:0] shift_ff, shift_in;
   logic [HASH_W-1:0] hold_ff, hold_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              held_ff, held_in;
   logic              rsp_xfer;
   logic              last;

   assign last     = cnt_ff == LAST_DIGIT;
   assign rsp_xfer = busy_ff && rsp_ready;
   // Holding slot empty, or the held hash moves up as the last character leaves
   assign free     = !held_ff || (rsp_xfer && last);

   // Shift register, digit counter, busy flag and holding slot
   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      hold_in  = hold_ff;
      held_in  = held_ff;
      if (rsp_xfer) begin
         shift_in = {shift_ff[HASH_W-NIB_W-1:0], NIB_W'(0)};
         cnt_in   = cnt_ff + CNT_W'(1);
         if (last)
            busy_in = 1'b0;
      end
      // Held hash starts once the current one is done
      if (!busy_in && held_ff) begin
         shift_in = hold_ff;
         cnt_in   = '0;
         busy_in  = 1'b1;
         held_in  = 1'b0;
      end
      // New hash goes straight out when idle, else waits in the slot
      if (load_in.load) begin
         if (!busy_in) begin
            shift_in = load_in.hash;
            cnt_in   = '0;
            busy_in  = 1'b1;
         end else begin
            hold_in = load_in.hash;
            held_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         held_ff <= held_in;
      end
      shift_ff <= shift_in;
      hold_ff  <= hold_in;
   end

   // Output character from the top nibble
   assign rsp_valid  = busy_ff;
   assign hex_char   = nib_to_ascii(shift_ff[HASH_W-1 -: NIB_W]);
   assign final_char = last;

   // Never load over a hash still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load_in.load |-> free)
      else $error("hash loaded while serializer full");

   // Busy drops only after the last character transfer
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(rsp_xfer && last))
      else $error("serializer idled early");

   // Counter only moves on a transfer or a load
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_xfer && !load_in.load |=> $stable(cnt_ff))
      else $error("digit counter moved without a transfer");

   // A hash waits only behind one being sent
   a_held_busy: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> busy_ff)
      else $error("held hash with serializer idle");

endmodule

### hw/rtl/fnv1_64_case_folded_hex_hasher_unit.sv
// ----------------------------------------------------------------------------
// fnv1_64_case_folded_hex_hasher_unit
// FNV-1 64-bit hash over case-folded message bytes, emitted as 16 hex chars.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transfer
//  req_bus | in  | data_byte[7:0] byte_present message_end  | valid & ready
//  rsp_bus | out | hex_char[6:0] final_char                 | valid & ready
//  csr_bus | in  | write_data (force_top_bit)               | valid & ready
//
//  A byte is hashed in the cycle it is taken: one item per cycle while ready,
//  set by the shift-add prime multiply feeding back into the hash register.
//  A closing item hands its hash to the serializer; its 16 characters leave
//  one per cycle while rsp_bus is ready; a further hash waits in a holding slot.
//  Input stalls only while that slot is full, until the last character of
//  the hash going out transfers. First characters appear the cycle after.
//  Reset (synchronous) sets the hash to the offset basis and force_top_bit to 1.
//  csr_bus is always ready.
// ----------------------------------------------------------------------------
module fnv1_64_case_folded_hex_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   fnvh_req_if.sink    req_bus,
   fnvh_rsp_if.source  rsp_bus,
   fnvh_csr_if.sink    csr_bus
);
   import fnvh_pkg::*;

   fnvh_load_type load;
   logic          ser_free;
   logic          req_xfer;
   logic          csr_xfer;

   assign req_bus.ready = ser_free;
   assign csr_bus.ready = 1'b1;
   assign req_xfer      = req_bus.valid && ser_free;
   assign csr_xfer      = csr_bus.valid;

   fnvh_hash_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_xfer     (req_xfer),
      .data_byte    (req_bus.data_byte),
      .byte_present (req_bus.byte_present),
      .message_end  (req_bus.message_end),
      .csr_xfer     (csr_xfer),
      .csr_data     (csr_bus.write_data),
      .load_out     (load)
   );

   fnvh_hex_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .load_in    (load),
      .free       (ser_free),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .hex_char   (rsp_bus.hex_char),
      .final_char (rsp_bus.final_char)
   );

endmodule

### verif/tb_fnv1_64_case_folded_hex_hasher_unit.sv
// ----------------------------------------------------------------------------
// tb_fnv1_64_case_folded_hex_hasher_unit
// Self-checking bench for the case-folded FNV-1 64-bit hex hasher. A directed
// table covers empty messages, letter-case boundaries, high bytes and absent
// bytes. It is followed by random messages under both settings of the
// top-bit control. Each hash digit that comes out is checked in order
// against a local hash predictor. Both channels idle at random, and the
// character sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_fnv1_64_case_folded_hex_hasher_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fnvh_pkg::*;

   localparam logic [HASH_W-1:0] PRIME_64     = 64'd1099511628211;
   localparam logic [HASH_W-1:0] DIGEST_OF_A  = 64'hAF63_BD4C_8601_B7BE;
   localparam int                SETTLE_CYCLES = 20;
   localparam int                LONG_HOLD     = 250;
   localparam int                HOLD_AFTER    = 200;
   localparam int                PHASE_ITEMS   = 105;
   localparam int                MAX_PRINTS    = 40;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } hex_digit_type;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              present;
      logic              closing;
      logic              known;
      logic [HASH_W-1:0] digest;
   } stim_row_type;

   logic clock;
   logic reset;

   fnvh_req_if req_bus ();
   fnvh_rsp_if rsp_bus ();
   fnvh_csr_if csr_bus ();

   fnv1_64_case_folded_hex_hasher_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   logic [HASH_W-1:0] hash_acc;
   logic              force_msb;
   hex_digit_type     expected_digits[$];
   stim_row_type      directed_rows[$];
   int                error_count;
   int                digits_taken;
   bit                long_hold_done;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] b);
      if (b >= 8'h41 && b <= 8'h5A)
         return b | 8'h20;
      return b;
   endfunction

   function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] prod;
      prod = h * PRIME_64;
      return prod ^ {56'd0, fold_upper(b)};
   endfunction

   // queue the 16 characters of a digest, most significant nibble first
   task automatic queue_hex_digits(input logic [HASH_W-1:0] digest);
      logic [NIB_W-1:0] nib;
      hex_digit_type    d;
      for (int k = 0; k < HEX_DIGITS; k++) begin
         nib    = digest[NIB_W*(HEX_DIGITS-1-k) +: NIB_W];
         d.ch   = (nib < NIB_TEN) ? ASCII_ZERO + CHAR_W'(nib)
                                  : ASCII_A + CHAR_W'(nib - NIB_TEN);
         d.last = (k == HEX_DIGITS - 1);
         expected_digits.push_back(d);
      end
   endtask

   // ---------------------------------------------------------------- reporting
   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTS)
         $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // ---------------------------------------------------------------- idling
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return BYTE_W'($urandom_range(8'h41, 8'h5A));
      if (r < 6)
         return BYTE_W'($urandom_range(8'h61, 8'h7A));
      if (r < 7) begin
         unique case ($urandom_range(0, 3))
            0: return 8'h40;
            1: return 8'h5B;
            2: return 8'h60;
            default: return 8'h7B;
         endcase
      end
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------- drivers
   // offer one item, wait for its transfer, then update the predictor
   task automatic send_item(input logic [BYTE_W-1:0] data, input logic present,
                            input logic closing, input logic known,
                            input logic [HASH_W-1:0] known_digest, input int gap);
      logic [HASH_W-1:0] digest;
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= data;
      req_bus.byte_present <= present;
      req_bus.message_end  <= closing;
      do
         @(posedge clock);
      while (!req_bus.ready);

      if (present)
         hash_acc = fnv_mix(hash_acc, data);
      if (closing) begin
         digest = force_msb ? (hash_acc | TOP_BIT) : hash_acc;
         queue_hex_digits(known ? known_digest : digest);
         hash_acc = FNV_BASIS;
      end

      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // drop valid and let everything expected come out
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_digits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_force(input logic value);
      @(negedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.write_data <= value;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      force_msb = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic add_row(input logic [BYTE_W-1:0] data, input logic present,
                          input logic closing, input logic known,
                          input logic [HASH_W-1:0] digest);
      stim_row_type row;
      row.data    = data;
      row.present = present;
      row.closing = closing;
      row.known   = known;
      row.digest  = digest;
      directed_rows.push_back(row);
   endtask

   // random messages, mostly short, closing item with or without a byte
   task automatic random_phase(input int quota);
      int  sent;
      int  len;
      int  r;
      bit  steady;
      logic present;
      sent = 0;
      while (sent < quota) begin
         r      = $urandom_range(0, 99);
         len    = (r < 70) ? $urandom_range(1, 8) :
                  (r < 90) ? $urandom_range(9, 24) : 0;
         steady = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            present = ($urandom_range(0, 9) != 0);
            send_item(pick_byte(), present, 1'b0, 1'b0, '0, steady ? 0 : idle_gap());
            sent++;
         end
         send_item(pick_byte(), 1'(($urandom_range(0, 1))), 1'b1, 1'b0, '0,
                   steady ? 0 : idle_gap());
         sent++;
      end
   endtask

   // ---------------------------------------------------------------- result sink
   initial begin
      int stall;
      int steady_left;
      rsp_bus.ready  = 1'b0;
      steady_left    = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && digits_taken >= HOLD_AFTER) begin
            // long hold-off: the block fills and stalls its input
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (steady_left > 0) begin
            steady_left--;
            rsp_bus.ready <= 1'b1;
         end else begin
            stall = idle_gap();
            if (stall == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
            if ($urandom_range(0, 19) == 0)
               steady_left = $urandom_range(20, 80);
         end
      end
   end

   // check each character transfer against the oldest expectation
   always @(posedge clock) begin
      hex_digit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         digits_taken++;
         if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h", rsp_bus.hex_char));
         end else begin
            want = expected_digits.pop_front();
            if (rsp_bus.hex_char !== want.ch)
               report_mismatch($sformatf("hex_char 0x%02h, expected 0x%02h",
                                         rsp_bus.hex_char, want.ch));
            if (rsp_bus.final_char !== want.last)
               report_mismatch($sformatf("final_char %b, expected %b",
                                         rsp_bus.final_char, want.last));
         end
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.data_byte    = '0;
      req_bus.byte_present = 1'b0;
      req_bus.message_end  = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.write_data   = 1'b0;
      hash_acc             = FNV_BASIS;
      force_msb            = 1'b1;
      error_count          = 0;
      digits_taken         = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, top bit forced as after reset
      add_row(8'hFF, 1'b0, 1'b1, 1'b1, FNV_BASIS);   // empty message
      add_row(8'h41, 1'b1, 1'b1, 1'b1, DIGEST_OF_A); // "A" folds to "a"
      add_row(8'h61, 1'b1, 1'b1, 1'b1, DIGEST_OF_A);
      add_row(8'h5A, 1'b0, 1'b0, 1'b0, '0);          // absent byte ignored
      add_row(8'h5A, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h40, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h5B, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h60, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h7B, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h7A, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);          // high bytes
      add_row(8'h80, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h7F, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h41, 1'b0, 1'b1, 1'b0, '0);          // close without a byte
      add_row(8'h48, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h65, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h4C, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h6C, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h4F, 1'b1, 1'b1, 1'b0, '0);          // close on a byte
      add_row(8'h00, 1'b0, 1'b1, 1'b1, FNV_BASIS);   // hash back at basis

      foreach (directed_rows[i])
         send_item(directed_rows[i].data, directed_rows[i].present,
                   directed_rows[i].closing, directed_rows[i].known,
                   directed_rows[i].digest, idle_gap());

      // random phases across both control settings
      wait_idle();
      write_force(1'b0);
      random_phase(PHASE_ITEMS);
      wait_idle();
      write_force(1'b1);
      random_phase(PHASE_ITEMS);
      wait_idle();
      write_force(1'b0);
      random_phase(PHASE_ITEMS);
      wait_idle();

      if (error_count == 0)
         $display("tb_fnv1_64_case_folded_hex_hasher_unit: PASS");
      else
         $display("tb_fnv1_64_case_folded_hex_hasher_unit: FAIL");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("tb_fnv1_64_case_folded_hex_hasher_unit: FAIL");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/fnvh_pkg.sv
hw/rtl/fnvh_if.sv
hw/rtl/fnvh_hash_core.sv
hw/rtl/fnvh_hex_serializer.sv
hw/rtl/fnv1_64_case_folded_hex_hasher_unit.sv
verif/tb_fnv1_64_case_folded_hex_hasher_unit.sv
